>>> rtl/vcbe_pkg.sv
package vcbe_pkg;

    localparam int NB_COUNT  = 13;
    localparam int NB_KW     = 4;
    localparam int DIV_STEPS = 61;
    localparam int DIV_CW    = 6;
    localparam int SUM_W     = 48;
    localparam int CNT_W     = 30;
    localparam int DIST_W    = 18;
    localparam int PIX_W     = 24;
    localparam int CFG_DW    = 10;
    localparam int CFG_IW    = 2;

    localparam logic [CFG_IW-1:0] REG_COLS   = 2'd0;
    localparam logic [CFG_IW-1:0] REG_ROWS   = 2'd1;
    localparam logic [CFG_IW-1:0] REG_PLANES = 2'd2;

    // neighbor offsets: 2-bit codes
    localparam logic [1:0] OFS_NEG  = 2'b11;
    localparam logic [1:0] OFS_ZERO = 2'b00;
    localparam logic [1:0] OFS_POS  = 2'b01;

    // entries 0..3 in the current plane, 4..12 in the previous one
    localparam logic [1:0] NB_DX [NB_COUNT] = '{
        OFS_NEG, OFS_NEG, OFS_ZERO, OFS_POS,
        OFS_ZERO, OFS_NEG, OFS_NEG, OFS_ZERO, OFS_POS, OFS_POS, OFS_POS, OFS_ZERO, OFS_NEG};
    localparam logic [1:0] NB_DY [NB_COUNT] = '{
        OFS_ZERO, OFS_NEG, OFS_NEG, OFS_NEG,
        OFS_ZERO, OFS_ZERO, OFS_NEG, OFS_NEG, OFS_NEG, OFS_ZERO, OFS_POS, OFS_POS, OFS_POS};
    localparam logic [NB_KW-1:0] NB_FIRST_PREV = 4'd4;
    localparam logic [NB_KW-1:0] NB_LAST       = 4'd12;

    typedef struct packed {
        logic             load_px;
        logic             rd;
        logic             sq;
        logic             acc;
        logic             wr;
        logic             div_init;
        logic             div_step;
        logic             out_load;
        logic [NB_KW-1:0] k;
    } t_cmd;

    typedef struct packed {
        logic nb_ok;
        logic last;
        logic out_busy;
    } t_sts;

endpackage

>>> rtl/vcbe_voxel_if.sv
interface vcbe_voxel_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    modport source(output valid, output red, output green, output blue, input ready);
    modport sink(input valid, input red, input green, input blue, output ready);
endinterface

>>> rtl/vcbe_result_if.sv
interface vcbe_result_if;
    logic        valid;
    logic        ready;
    logic [47:0] distance_sum;
    logic [29:0] pair_count;
    logic [47:0] beta_value;
    logic        beta_saturated;
    modport source(output valid, output distance_sum, output pair_count,
                   output beta_value, output beta_saturated, input ready);
    modport sink(input valid, input distance_sum, input pair_count,
                 input beta_value, input beta_saturated, output ready);
endinterface

>>> rtl/vcbe_ram.sv
module vcbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/vcbe_datapath.sv
module vcbe_datapath #(
    parameter int MAX_COLS   = 512,
    parameter int MAX_ROWS   = 512,
    parameter int MAX_PLANES = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vcbe_pkg::t_cmd               i_cmd,
    output vcbe_pkg::t_sts               o_sts,
    input  logic                         i_cfg_we,
    input  logic [vcbe_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [vcbe_pkg::CFG_DW-1:0]  i_cfg_data,
    vcbe_voxel_if.sink                   i_voxel,
    vcbe_result_if.source                o_result
);
    localparam int XW    = $clog2(MAX_COLS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int ZW    = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int PLANE = MAX_COLS * MAX_ROWS;
    localparam int DEPTH = 2 * PLANE;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = vcbe_pkg::SUM_W;
    localparam int CW    = vcbe_pkg::CNT_W;
    localparam int QW    = CW + 31;

    logic [vcbe_pkg::PIX_W-1:0]  r_px;
    logic [XW-1:0]               r_x, r_xlast, nx;
    logic [YW-1:0]               r_y, r_ylast, ny, ay;
    logic [ZW-1:0]               r_z, r_zlast;
    logic [SW-1:0]               r_sum;
    logic [CW-1:0]               r_cnt;
    logic [vcbe_pkg::DIST_W-1:0] r_dist;
    logic [SW:0]                 r_rem;
    logic [QW-1:0]               r_quo;
    logic                        r_ov, r_sat;
    logic [SW-1:0]               r_osum, r_obeta;
    logic [CW-1:0]               r_ocnt;

    logic [1:0]                  dx, dy;
    logic                        prev, half, ok;
    logic [XW-1:0]               ax;
    logic [AW-1:0]               base, addr;
    logic [vcbe_pkg::PIX_W-1:0]  rdata;
    logic signed [8:0]           dr, dg, db;
    logic [16:0]                 sr, sg, sb;
    logic [SW:0]                 sum_next, div_t;
    logic [31:0]                 c_cols, c_rows, c_planes;

    assign dx   = vcbe_pkg::NB_DX[i_cmd.k];
    assign dy   = vcbe_pkg::NB_DY[i_cmd.k];
    assign prev = (i_cmd.k >= vcbe_pkg::NB_FIRST_PREV);

    always_comb begin
        ok = 1'b1;
        if (prev && r_z == '0) ok = 1'b0;
        if (dx == vcbe_pkg::OFS_NEG && r_x == '0) ok = 1'b0;
        if (dx == vcbe_pkg::OFS_POS && r_x == r_xlast) ok = 1'b0;
        if (dy == vcbe_pkg::OFS_NEG && r_y == '0) ok = 1'b0;
        if (dy == vcbe_pkg::OFS_POS && r_y == r_ylast) ok = 1'b0;
    end

    always_comb begin
        nx = r_x;
        if (dx == vcbe_pkg::OFS_NEG) nx = r_x - 1'b1;
        if (dx == vcbe_pkg::OFS_POS) nx = r_x + 1'b1;
        ny = r_y;
        if (dy == vcbe_pkg::OFS_NEG) ny = r_y - 1'b1;
        if (dy == vcbe_pkg::OFS_POS) ny = r_y + 1'b1;
    end

    // one address path: the store position on write, the neighbor on read
    assign ax   = i_cmd.wr ? r_x : nx;
    assign ay   = i_cmd.wr ? r_y : ny;
    assign half = r_z[0] ^ (prev & ~i_cmd.wr);
    assign base = AW'(ay) * AW'(MAX_COLS) + AW'(ax);
    assign addr = half ? base + AW'(PLANE) : base;

    vcbe_ram #(.WIDTH(vcbe_pkg::PIX_W), .DEPTH(DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.wr),
        .i_waddr(addr),
        .i_wdata(r_px),
        .i_re   (i_cmd.rd),
        .i_raddr(addr),
        .o_rdata(rdata)
    );

    assign dr = $signed({1'b0, r_px[7:0]})   - $signed({1'b0, rdata[7:0]});
    assign dg = $signed({1'b0, r_px[15:8]})  - $signed({1'b0, rdata[15:8]});
    assign db = $signed({1'b0, r_px[23:16]}) - $signed({1'b0, rdata[23:16]});
    assign sr = 17'(dr * dr);
    assign sg = 17'(dg * dg);
    assign sb = 17'(db * db);

    assign sum_next = {1'b0, r_sum} + (SW+1)'(r_dist);
    assign div_t    = {r_rem[SW-1:0], r_quo[QW-1]};

    always_comb begin
        c_cols = (i_cfg_data == '0) ? 32'd1 : 32'(i_cfg_data);
        if (c_cols > 32'(MAX_COLS)) c_cols = 32'(MAX_COLS);
        c_rows = (i_cfg_data == '0) ? 32'd1 : 32'(i_cfg_data);
        if (c_rows > 32'(MAX_ROWS)) c_rows = 32'(MAX_ROWS);
        c_planes = (i_cfg_data[8:0] == '0) ? 32'd1 : 32'(i_cfg_data[8:0]);
        if (c_planes > 32'(MAX_PLANES)) c_planes = 32'(MAX_PLANES);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x     <= '0;
            r_y     <= '0;
            r_z     <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
            r_xlast <= XW'(((MAX_COLS < 512) ? MAX_COLS : 512) - 1);
            r_ylast <= YW'(((MAX_ROWS < 512) ? MAX_ROWS : 512) - 1);
            r_zlast <= '0;
        end else begin
            if (o_result.ready) r_ov <= 1'b0;
            if (i_cfg_we && i_cfg_index <= vcbe_pkg::REG_PLANES) begin
                r_x   <= '0;
                r_y   <= '0;
                r_z   <= '0;
                r_sum <= '0;
                r_cnt <= '0;
                unique case (i_cfg_index)
                    vcbe_pkg::REG_COLS:   r_xlast <= XW'(c_cols - 32'd1);
                    vcbe_pkg::REG_ROWS:   r_ylast <= YW'(c_rows - 32'd1);
                    default:              r_zlast <= ZW'(c_planes - 32'd1);
                endcase
            end
            if (i_cmd.acc) begin
                r_sum <= sum_next[SW] ? '1 : sum_next[SW-1:0];
                if (r_cnt != '1) r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.wr) begin
                if (r_x != r_xlast) begin
                    r_x <= r_x + 1'b1;
                end else begin
                    r_x <= '0;
                    if (r_y != r_ylast) begin
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_y <= '0;
                        r_z <= (r_z != r_zlast) ? r_z + 1'b1 : '0;
                    end
                end
            end
            if (i_cmd.out_load) begin
                r_ov  <= 1'b1;
                r_sum <= '0;
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_px) r_px <= {i_voxel.blue, i_voxel.green, i_voxel.red};
        if (i_cmd.sq) r_dist <= vcbe_pkg::DIST_W'(sr) + vcbe_pkg::DIST_W'(sg)
                               + vcbe_pkg::DIST_W'(sb);
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= {r_cnt, 31'd0};
        end
        if (i_cmd.div_step) begin
            if (div_t >= {1'b0, r_sum}) begin
                r_rem <= div_t - {1'b0, r_sum};
                r_quo <= {r_quo[QW-2:0], 1'b1};
            end else begin
                r_rem <= div_t;
                r_quo <= {r_quo[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            r_osum <= r_sum;
            r_ocnt <= r_cnt;
            if (r_sum == '0) begin
                r_obeta <= '0;
                r_sat   <= 1'b0;
            end else if (r_quo[QW-1:SW] != '0) begin
                r_obeta <= '1;
                r_sat   <= 1'b1;
            end else begin
                r_obeta <= r_quo[SW-1:0];
                r_sat   <= 1'b0;
            end
        end
    end

    assign o_sts.nb_ok    = ok;
    assign o_sts.last     = (r_x == r_xlast) && (r_y == r_ylast) && (r_z == r_zlast);
    assign o_sts.out_busy = r_ov && !o_result.ready;

    assign o_result.valid          = r_ov;
    assign o_result.distance_sum   = r_osum;
    assign o_result.pair_count     = r_ocnt;
    assign o_result.beta_value     = r_obeta;
    assign o_result.beta_saturated = r_sat;
endmodule

>>> rtl/vcbe_ctrl.sv
module vcbe_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  vcbe_pkg::t_sts i_sts,
    output vcbe_pkg::t_cmd o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_WAIT, S_ACC, S_STORE, S_DIV, S_OUT
    } t_state;

    t_state                        r_state;
    logic [vcbe_pkg::NB_KW-1:0]    r_k;
    logic [vcbe_pkg::DIV_CW-1:0]   r_dcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_dcnt  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    if (i_in_valid) r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (i_sts.nb_ok) begin
                        r_state <= S_WAIT;
                    end else if (r_k == vcbe_pkg::NB_LAST) begin
                        r_state <= S_STORE;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_WAIT: r_state <= S_ACC;
                S_ACC: begin
                    if (r_k == vcbe_pkg::NB_LAST) begin
                        r_state <= S_STORE;
                    end else begin
                        r_k     <= r_k + 1'b1;
                        r_state <= S_LOOK;
                    end
                end
                S_STORE: begin
                    r_dcnt  <= '0;
                    r_state <= i_sts.last ? S_DIV : S_IDLE;
                end
                S_DIV: begin
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == vcbe_pkg::DIV_CW'(vcbe_pkg::DIV_STEPS - 1)) r_state <= S_OUT;
                end
                S_OUT: if (!i_sts.out_busy) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.k        = r_k;
        o_cmd.load_px  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.rd       = (r_state == S_LOOK) && i_sts.nb_ok;
        o_cmd.sq       = (r_state == S_WAIT);
        o_cmd.acc      = (r_state == S_ACC);
        o_cmd.wr       = (r_state == S_STORE);
        o_cmd.div_init = (r_state == S_STORE) && i_sts.last;
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.out_load = (r_state == S_OUT) && !i_sts.out_busy;
    end
endmodule

>>> rtl/volume_contrast_beta_estimator_top.sv
// Volume contrast estimator: takes RGB voxels in raster order (x, y, then plane) and,
// after the last voxel of the volume, returns the summed squared color distance over
// up to 13 causal neighbors, the pair count and beta = count / (2 * sum) in Q16.32.
// Neighbors are read one by one through the single read port of the plane store, and
// a new voxel is taken only after the previous one is done; the last one also runs the
// bit-serial division, and it stalls while an earlier result still waits to be taken.
// A result waits in an output register, so the next volume can start while it is
// pending. A register write restarts the volume.
module volume_contrast_beta_estimator_top #(
    parameter int MAX_COLS   = 512,
    parameter int MAX_ROWS   = 512,
    parameter int MAX_PLANES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [vcbe_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [vcbe_pkg::CFG_DW-1:0] i_cfg_data,
    vcbe_voxel_if.sink                  i_voxel,
    vcbe_result_if.source               o_result
);
    vcbe_pkg::t_cmd cmd;
    vcbe_pkg::t_sts sts;

    vcbe_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_voxel.valid),
        .o_in_ready(i_voxel.ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    vcbe_datapath #(
        .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .MAX_PLANES(MAX_PLANES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_voxel    (i_voxel),
        .o_result   (o_result)
    );
endmodule

>>> rtl/vcbe_chk.sv
module vcbe_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [47:0] i_sum,
    input logic [47:0] i_beta,
    input logic        i_sat
);
    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    // one voxel at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input taken twice in a row");

    // the bit-serial division lies between the final voxel and its result
    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##1 !$rose(i_out_valid))
        else $error("result right after an item");

    a_sat_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_sat) |-> (i_beta == '1))
        else $error("saturated beta not clamped");

    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_sum == '0) |-> (i_beta == '0 && !i_sat))
        else $error("nonzero beta with zero sum");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_beta)))
        else $error("result dropped while stalled");
endmodule

bind volume_contrast_beta_estimator_top vcbe_chk u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_voxel.valid),
    .i_in_ready (i_voxel.ready),
    .i_out_valid(o_result.valid),
    .i_out_ready(o_result.ready),
    .i_sum      (o_result.distance_sum),
    .i_beta     (o_result.beta_value),
    .i_sat      (o_result.beta_saturated)
);
